FILE: src/ped_pkg.sv
`timescale 1ns / 1ps
package ped_pkg;

  // escape introducer
  localparam logic [7:0] PCT_CHAR = 8'h25;

  // largest number of result bytes that one input byte can release
  localparam int MAX_OUT = 3;

  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_AFTER_PCT = 2'd1,
    PH_AFTER_HI  = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } result_t;

  // one decoded request: 1 to 3 bytes, last flag applies to the final one
  typedef struct packed {
    logic [1:0]               cnt;
    logic [MAX_OUT-1:0][7:0]  bytes;
    logic                     last;
  } entry_t;

  // hex digit check: {valid, value}; letters map to 10..15 through the low nibble
  function automatic logic [4:0] hex_of(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b inside {[8'h30:8'h39]}) begin
      r = {1'b1, b[3:0]};
    end else if (b inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      r = {1'b1, b[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

FILE: src/ped_front.sv
`timescale 1ns / 1ps
module ped_front import ped_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   accept,
  input  item_t  item,
  output logic   enq,
  output entry_t entry
);

  phase_t     phase, phase_next;
  logic [7:0] held_digit, held_digit_next;

  // classify the byte against the escape phase
  always_comb begin
    logic [4:0] lo;
    logic [4:0] hi;
    logic [1:0] n;
    logic       tail;
    logic [7:0] b;
    b               = item.in_byte;
    lo              = hex_of(b);
    hi              = hex_of(held_digit);
    phase_next      = PH_IDLE;
    held_digit_next = held_digit;
    n               = 2'd0;
    tail            = 1'b1;
    entry.bytes     = '0;
    entry.last      = item.in_last;
    case (phase)
      PH_AFTER_PCT: begin
        if (lo[4] && !item.in_last) begin
          held_digit_next = b;
          phase_next      = PH_AFTER_HI;
          tail            = 1'b0;
        end else begin
          entry.bytes[0] = PCT_CHAR;
          n              = 2'd1;
        end
      end
      PH_AFTER_HI: begin
        if (lo[4]) begin
          entry.bytes[0] = {hi[3:0], lo[3:0]};
          n              = 2'd1;
          tail           = 1'b0;
        end else begin
          entry.bytes[0] = PCT_CHAR;
          entry.bytes[1] = held_digit;
          n              = 2'd2;
        end
      end
      default: begin
        n = 2'd0;
      end
    endcase
    // remaining byte handled as from idle
    if (tail) begin
      if (b == PCT_CHAR && !item.in_last) begin
        phase_next = PH_AFTER_PCT;
      end else begin
        case (n)
          2'd0:    entry.bytes[0] = b;
          2'd1:    entry.bytes[1] = b;
          default: entry.bytes[2] = b;
        endcase
        n = n + 2'd1;
      end
    end
    entry.cnt = n;
    enq       = accept && (n != 2'd0);
  end

  // escape state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else if (accept) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_digit <= held_digit_next;
    end
  end

endmodule

FILE: src/ped_queue.sv
`timescale 1ns / 1ps
module ped_queue import ped_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   enq,
  input  entry_t wr_entry,
  input  logic   deq,
  output logic   full,
  output logic   has_head,
  output entry_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full     = (count == CNT_W'(DEPTH));
  assign has_head = (count != '0);
  assign head     = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (enq) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (enq) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (deq) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (enq && !deq) begin
        count <= count + 1'b1;
      end else if (deq && !enq) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: src/ped_back.sv
`timescale 1ns / 1ps
module ped_back import ped_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    has_head,
  input  entry_t  head,
  input  logic    pop,
  output logic    deq,
  output logic    empty,
  output result_t result
);

  logic [1:0] idx;
  logic       final_byte;

  assign empty      = !has_head;
  assign final_byte = (idx == head.cnt - 2'd1);
  assign deq        = pop && has_head && final_byte;

  // pick the byte of the head request
  always_comb begin
    case (idx)
      2'd0:    result.out_byte = head.bytes[0];
      2'd1:    result.out_byte = head.bytes[1];
      default: result.out_byte = head.bytes[2];
    endcase
    result.out_last = head.last && final_byte;
  end

  // walk through the bytes of one request
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (pop && has_head) begin
      idx <= final_byte ? 2'd0 : idx + 2'd1;
    end
  end

endmodule

FILE: src/percent_escape_decoder.sv
`timescale 1ns / 1ps
// Streaming percent-escape decoder: push one byte of an escaped string per cycle
// (with a mark on the string's final byte) and pop decoded bytes. A '%' with two
// hex digits becomes one byte; a broken or cut escape comes out verbatim. Input is
// taken at one byte per cycle as long as the request queue (QUEUE_DEPTH entries)
// has room; each input that yields output makes one request. The output side
// delivers one byte per pop, so a request of two or three bytes (broken escapes)
// holds the queue head for one pop per byte; such a request always follows
// input bytes that gave no output, so a receiver that pops every cycle keeps up
// and full rises only while pop is held off. A result is registered in the
// request queue before it becomes visible at the output.
module percent_escape_decoder import ped_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  output logic    full,
  input  item_t   item,
  output logic    empty,
  input  logic    pop,
  output result_t result
);

  logic   accept;
  logic   enq;
  logic   deq;
  logic   has_head;
  entry_t wr_entry;
  entry_t head;

  assign accept = push && !full;

  // front: escape tracking and request build
  ped_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .enq    (enq),
    .entry  (wr_entry)
  );

  // request queue between the two sides
  ped_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .enq      (enq),
    .wr_entry (wr_entry),
    .deq      (deq),
    .full     (full),
    .has_head (has_head),
    .head     (head)
  );

  // back: byte-by-byte delivery
  ped_back u_back (
    .clk      (clk),
    .rst      (rst),
    .has_head (has_head),
    .head     (head),
    .pop      (pop),
    .deq      (deq),
    .empty    (empty),
    .result   (result)
  );

endmodule
